### hdl/mmscan_pkg.sv
// shared types, constants and decode helpers for the movz/movk immediate scanner
// no dependencies; imported by every module of the block
package mmscan_pkg;

    localparam int VALUE_W  = 64;
    localparam int INSTR_W  = 32;
    localparam int REG_W    = 5;
    localparam int NUM_REGS = 32;
    localparam int HW_W     = 2;
    localparam int IMM_W    = 16;

    localparam logic [INSTR_W-1:0] OP_MASK = 32'hFF80_0000;
    localparam logic [INSTR_W-1:0] OP_MOVZ = 32'hD280_0000;
    localparam logic [INSTR_W-1:0] OP_MOVK = 32'hF280_0000;
    localparam logic [IMM_W-1:0]   HALF_MASK = 16'hFFFF;

    localparam logic [VALUE_W-1:0] MIN_ADDRESS_RESET = 64'h0000_0001_0000_0000;
    localparam logic [REG_W-1:0]   LAST_REG = 5'd31;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_FRD,
        S_FCHK,
        S_FEND
    } state_t;

    // one read port and one write port of the value store
    typedef struct packed {
        logic               rd_en;
        logic [REG_W-1:0]   rd_addr;
        logic               wr_en;
        logic [REG_W-1:0]   wr_addr;
        logic [VALUE_W-1:0] wr_data;
    } mem_req_t;

    // one result headed for the output register
    typedef struct packed {
        logic               push;
        logic [VALUE_W-1:0] value;
        logic [REG_W-1:0]   dest;
        logic               last;
    } out_push_t;

    // immediate placed at its halfword position
    function automatic logic [VALUE_W-1:0] place_half(input logic [IMM_W-1:0] imm,
                                                      input logic [HW_W-1:0] hw);
        logic [VALUE_W-1:0] wide;
        wide = {{(VALUE_W-IMM_W){1'b0}}, imm};
        return wide << {hw, 4'b0000};
    endfunction

endpackage

### hdl/mmscan_if.sv
// handshake channels of the scanner: instruction items in, results out
// depends on mmscan_pkg for field widths
interface mmscan_item_if;
    import mmscan_pkg::*;

    logic               valid;
    logic               ready;
    logic [INSTR_W-1:0] instruction;
    logic               flush;

    modport source (output valid, output instruction, output flush, input ready);
    modport sink   (input valid, input instruction, input flush, output ready);
endinterface

interface mmscan_result_if;
    import mmscan_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] suspect_value;
    logic [REG_W-1:0]   dest_register;
    logic               last;

    modport source (output valid, output suspect_value, output dest_register,
                    output last, input ready);
    modport sink   (input valid, input suspect_value, input dest_register,
                    input last, output ready);
endinterface

### hdl/movz_movk_immediate_address_scanner_top.sv
// top level of the movz/movk immediate scanner: sequencer, live marks, threshold
// depends on mmscan_pkg, mmscan_if, mmscan_value_mem, mmscan_out_stage
//
//   channel   dir  handshake            payload
//   item      in   valid/ready          instruction[31:0], flush
//   result    out  valid/ready          suspect_value[63:0], dest_register[4:0], last
//   cfg       in   cfg_we (no ready)    cfg_wdata[63:0] -> min_address
//
// an instruction transaction reads the register's value from the store in S_IDLE, then
// in S_EXEC modifies, writes back and hands any qualifying result to the output register.
// a flush transaction walks all 32 registers, reading then checking each (S_FRD,
// S_FCHK), and then releases the final held result in S_FEND.
// reset clears the live marks and the sequencer; the value store is not cleared.
// a result waits in the output register; the sequencer stalls only when it must
// hand over another result while that register is still full.
module movz_movk_immediate_address_scanner_top (
    input  logic                               clk,
    input  logic                               rst_n,
    mmscan_item_if.sink                        item,
    mmscan_result_if.source                    result,
    input  logic                               cfg_we,
    input  logic [mmscan_pkg::VALUE_W-1:0]     cfg_wdata
);
    import mmscan_pkg::*;

    // sequencer state
    state_t state_reg;
    state_t state_next;

    // threshold register
    logic [VALUE_W-1:0] min_address_reg;

    // held instruction word and flush walk index
    logic [INSTR_W-1:0] instr_reg;
    logic [REG_W-1:0]   idx_reg;

    // one live mark per register, in flops so reset clears them at once
    logic [NUM_REGS-1:0] live_reg;
    logic [NUM_REGS-1:0] live_next;

    // during a flush the latest qualifying result is held back until we know
    // whether another one follows, so that last lands on the final one
    logic               held_valid_reg;
    logic               held_valid_next;
    logic [VALUE_W-1:0] held_value_reg;
    logic [REG_W-1:0]   held_dest_reg;
    logic               held_load;

    // store and output stage connections
    mem_req_t           mem_req;
    logic [VALUE_W-1:0] rd_data;
    out_push_t          push;
    logic               out_free;

    // instruction decode on the held word
    logic               is_movz;
    logic               is_movk;
    logic [REG_W-1:0]   rd;
    logic [HW_W-1:0]    hw;
    logic [IMM_W-1:0]   imm;
    logic [VALUE_W-1:0] placed;
    logic [VALUE_W-1:0] merged;
    logic               qualifies;
    logic               live_rd;
    logic               close_rd;
    logic               exec_stall;
    logic               fchk_hit;
    logic               fchk_stall;
    logic               fend_stall;

    assign is_movz = (instr_reg & OP_MASK) == OP_MOVZ;
    assign is_movk = (instr_reg & OP_MASK) == OP_MOVK;
    assign rd      = instr_reg[REG_W-1:0];
    assign hw      = instr_reg[22:21];
    assign imm     = instr_reg[20:5];
    assign placed  = place_half(imm, hw);
    assign merged  = (rd_data & ~place_half(HALF_MASK, hw)) | placed;

    // single wide compare shared by the instruction and flush paths
    assign qualifies = rd_data >= min_address_reg;

    assign live_rd  = live_reg[rd];
    // movz on a live register closes the old run; so does any non-movk word
    assign close_rd = live_rd && (is_movz || !is_movk);
    assign exec_stall = close_rd && qualifies && !out_free;

    assign fchk_hit   = live_reg[idx_reg] && qualifies;
    assign fchk_stall = fchk_hit && held_valid_reg && !out_free;
    assign fend_stall = held_valid_reg && !out_free;

    mmscan_value_mem u_value_mem (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    mmscan_out_stage u_out_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .push_in (push),
        .free    (out_free),
        .result  (result)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                begin
                    state_next = item.flush ? S_FRD : S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!exec_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            S_FRD:
            begin
                state_next = S_FCHK;
            end
            S_FCHK:
            begin
                if (!fchk_stall)
                begin
                    state_next = (idx_reg == LAST_REG) ? S_FEND : S_FRD;
                end
            end
            S_FEND:
            begin
                if (!fend_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        item.ready      = 1'b0;
        mem_req         = '0;
        push            = '0;
        live_next       = live_reg;
        held_valid_next = held_valid_reg;
        held_load       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                item.ready      = 1'b1;
                // read the named register right away so the value is there next cycle
                mem_req.rd_en   = item.valid && !item.flush;
                mem_req.rd_addr = item.instruction[REG_W-1:0];
            end
            S_EXEC:
            begin
                if (!exec_stall)
                begin
                    push.push  = close_rd && qualifies;
                    push.value = rd_data;
                    push.dest  = rd;
                    push.last  = 1'b1;
                    mem_req.wr_addr = rd;
                    if (is_movz)
                    begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_data = placed;
                        live_next[rd]   = 1'b1;
                    end
                    else if (is_movk && live_rd)
                    begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_data = merged;
                    end
                    else
                    begin
                        live_next[rd] = 1'b0;
                    end
                end
            end
            S_FRD:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = idx_reg;
            end
            S_FCHK:
            begin
                if (!fchk_stall)
                begin
                    // a newer hit means the held one is not the final result
                    push.push  = fchk_hit && held_valid_reg;
                    push.value = held_value_reg;
                    push.dest  = held_dest_reg;
                    push.last  = 1'b0;
                    held_load  = fchk_hit;
                    if (fchk_hit)
                    begin
                        held_valid_next = 1'b1;
                    end
                    live_next[idx_reg] = 1'b0;
                end
            end
            S_FEND:
            begin
                if (!fend_stall)
                begin
                    push.push       = held_valid_reg;
                    push.value      = held_value_reg;
                    push.dest       = held_dest_reg;
                    push.last       = 1'b1;
                    held_valid_next = 1'b0;
                end
            end
            default:
            begin
                item.ready = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            live_reg        <= '0;
            held_valid_reg  <= 1'b0;
            min_address_reg <= MIN_ADDRESS_RESET;
            idx_reg         <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            live_reg       <= live_next;
            held_valid_reg <= held_valid_next;
            if (cfg_we)
            begin
                min_address_reg <= cfg_wdata;
            end
            if (state_reg == S_IDLE)
            begin
                idx_reg <= '0;
            end
            else if (state_reg == S_FCHK && !fchk_stall)
            begin
                idx_reg <= idx_reg + 5'd1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            instr_reg <= item.instruction;
        end
        if (held_load)
        begin
            held_value_reg <= rd_data;
            held_dest_reg  <= idx_reg;
        end
    end
endmodule

### hdl/mmscan_value_mem.sv
// per-register value store: 32 x 64, one write and one registered read per cycle
// depends on mmscan_pkg
module mmscan_value_mem (
    input  logic                        clk,
    input  mmscan_pkg::mem_req_t        req,
    output logic [mmscan_pkg::VALUE_W-1:0] rd_data
);
    import mmscan_pkg::*;

    logic [VALUE_W-1:0] mem [NUM_REGS];
    logic [VALUE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

### hdl/mmscan_out_stage.sv
// output register for result transactions; frees when the consumer takes it
// depends on mmscan_pkg and mmscan_result_if
module mmscan_out_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mmscan_pkg::out_push_t push_in,
    output logic                  free,
    mmscan_result_if.source       result
);
    import mmscan_pkg::*;

    logic               valid_reg;
    logic               valid_next;
    logic [VALUE_W-1:0] value_reg;
    logic [REG_W-1:0]   dest_reg;
    logic               last_reg;

    assign free = !valid_reg || result.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (push_in.push)
        begin
            valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_in.push)
        begin
            value_reg <= push_in.value;
            dest_reg  <= push_in.dest;
            last_reg  <= push_in.last;
        end
    end

    assign result.valid         = valid_reg;
    assign result.suspect_value = value_reg;
    assign result.dest_register = dest_reg;
    assign result.last          = last_reg;
endmodule
